// File: sv/tli_pkg.sv
// shared constants and types of the table linear interpolator
// no dependencies; the design files refer to this package by scoped names, the testbench imports it
`default_nettype none

package tli_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int INDEX_W       = 6;
  localparam int COUNT_W       = 7;
  localparam int CODE_W        = 12;
  localparam int TEMP_W        = 16;
  localparam int FRACTION_BITS = 4;
  localparam int PROD_W        = 2 * TEMP_W;
  localparam int DIV_CYCLES    = PROD_W / 2;
  localparam int DIV_CNT_W     = 4;

  localparam logic [COUNT_W-1:0] ENTRIES_RESET = 7'd53;
  localparam logic [COUNT_W-1:0] COUNT_MIN     = 7'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'(TABLE_DEPTH);

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  localparam logic [1:0] STATUS_INTERP = 2'd0;
  localparam logic [1:0] STATUS_BELOW  = 2'd1;
  localparam logic [1:0] STATUS_ABOVE  = 2'd2;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    logic [CODE_W-1:0]  code;
    logic [TEMP_W-1:0]  temp;
  } load_t;

  typedef struct packed {
    logic              valid;
    logic              done;
    logic [1:0]        status;
    logic [CODE_W-1:0] sample;
    logic [CODE_W-1:0] code_lo;
    logic [TEMP_W-1:0] temp_lo;
    logic [CODE_W-1:0] code_hi;
    logic [TEMP_W-1:0] temp_hi;
  } token_t;

endpackage

`default_nettype wire

// File: sv/tli_intf.sv
// channel interfaces of the table linear interpolator: input, result, config
// depends on tli_pkg
`default_nettype none

interface tli_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [tli_pkg::INDEX_W-1:0]  entry_index;
  logic [tli_pkg::CODE_W-1:0]   entry_code;
  logic [tli_pkg::TEMP_W-1:0]   entry_temperature;
  logic [tli_pkg::CODE_W-1:0]   sample;

  modport source (output valid, mode, entry_index, entry_code, entry_temperature, sample,
                  input ready);
  modport sink   (input valid, mode, entry_index, entry_code, entry_temperature, sample,
                  output ready);
endinterface

interface tli_out_if;
  logic                         valid;
  logic                         ready;
  logic [tli_pkg::TEMP_W-1:0]   temperature;
  logic [1:0]                   range_status;

  modport source (output valid, temperature, range_status, input ready);
  modport sink   (input valid, temperature, range_status, output ready);
endinterface

interface tli_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [tli_pkg::COUNT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: sv/tli_cell.sv
// one table cell: holds one calibration pair and one stage of the search token
// depends on tli_pkg
`default_nettype none

module tli_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [tli_pkg::INDEX_W-1:0]  idx_i,
  input  wire logic [tli_pkg::COUNT_W-1:0]  count_i,
  input  wire tli_pkg::load_t               load_i,
  input  wire logic [tli_pkg::CODE_W-1:0]   prev_code_i,
  input  wire logic [tli_pkg::TEMP_W-1:0]   prev_temp_i,
  output logic      [tli_pkg::CODE_W-1:0]   code_o,
  output logic      [tli_pkg::TEMP_W-1:0]   temp_o,
  input  wire tli_pkg::token_t              token_i,
  output tli_pkg::token_t                   token_o
);

  logic [tli_pkg::CODE_W-1:0] code_q;
  logic [tli_pkg::TEMP_W-1:0] temp_q;
  tli_pkg::token_t            token_d, token_q;
  logic                       in_use, last;

  always_ff @(posedge clk_i) begin
    if (load_i.en && load_i.index == idx_i) begin
      code_q <= load_i.code;
      temp_q <= load_i.temp;
    end
  end

  assign in_use = {1'b0, idx_i} < count_i;
  assign last   = {1'b0, idx_i} == (count_i - 7'd1);

  always_comb begin
    token_d = token_i;
    if (token_i.valid && !token_i.done && in_use) begin
      if (code_q >= token_i.sample) begin
        token_d.done = 1'b1;
        if (idx_i == '0) begin
          token_d.status  = tli_pkg::STATUS_BELOW;
          token_d.temp_lo = temp_q;
        end else begin
          token_d.status  = tli_pkg::STATUS_INTERP;
          token_d.code_lo = prev_code_i;
          token_d.temp_lo = prev_temp_i;
          token_d.code_hi = code_q;
          token_d.temp_hi = temp_q;
        end
      end else if (last) begin
        token_d.done    = 1'b1;
        token_d.status  = tli_pkg::STATUS_ABOVE;
        token_d.temp_lo = temp_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
    end else begin
      token_q <= token_d;
    end
  end

  assign code_o  = code_q;
  assign temp_o  = temp_q;
  assign token_o = token_q;

endmodule

`default_nettype wire

// File: sv/tli_arith.sv
// interpolation unit: one multiply, restoring divide two bits per cycle, result register
// depends on tli_pkg
`default_nettype none

module tli_arith (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tli_pkg::token_t             token_i,
  output logic                             res_valid_o,
  input  wire logic                        res_ready_i,
  output logic      [tli_pkg::TEMP_W-1:0]  temperature_o,
  output logic      [1:0]                  status_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [tli_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [tli_pkg::CODE_W-1:0]    div_q;
  logic [tli_pkg::TEMP_W-1:0]    mul_a_q, mul_b_q, base_q, res_q;
  logic [tli_pkg::PROD_W-1:0]    acc_q, acc_d;
  logic [tli_pkg::CODE_W-1:0]    rem_q, rem_d;
  logic [1:0]                    status_q;
  logic [tli_pkg::CODE_W-1:0]    sample_diff;

  assign sample_diff = token_i.sample - token_i.code_lo;

  // two restoring division steps
  always_comb begin
    logic [tli_pkg::CODE_W:0] trial;
    acc_d = acc_q;
    rem_d = rem_q;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_d, acc_d[tli_pkg::PROD_W-1]};
      if (trial >= {1'b0, div_q}) begin
        rem_d = tli_pkg::CODE_W'(trial - {1'b0, div_q});
        acc_d = {acc_d[tli_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[tli_pkg::CODE_W-1:0];
        acc_d = {acc_d[tli_pkg::PROD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (token_i.valid) begin
          state_d = (token_i.status == tli_pkg::STATUS_INTERP) ? S_MUL : S_DONE;
        end
      end
      S_MUL:  state_d = S_DIV;
      S_DIV: begin
        if (cnt_q == tli_pkg::DIV_CNT_W'(tli_pkg::DIV_CYCLES - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN:  state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (token_i.valid) begin
          base_q   <= token_i.temp_lo;
          res_q    <= token_i.temp_lo;
          status_q <= token_i.status;
          mul_a_q  <= token_i.temp_lo - token_i.temp_hi;
          mul_b_q  <= tli_pkg::TEMP_W'({4'b0, sample_diff} << tli_pkg::FRACTION_BITS);
          div_q    <= token_i.code_hi - token_i.code_lo;
        end
      end
      S_MUL: begin
        acc_q <= tli_pkg::PROD_W'(mul_a_q) * tli_pkg::PROD_W'(mul_b_q);
        rem_q <= '0;
      end
      S_DIV: begin
        acc_q <= acc_d;
        rem_q <= rem_d;
      end
      S_FIN: begin
        res_q <= base_q - acc_q[tli_pkg::FRACTION_BITS +: tli_pkg::TEMP_W];
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o   = (state_q == S_DONE);
  assign temperature_o = res_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

// File: sv/table_linear_interpolator_unit.sv
// convert: scan down the 64-cell chain, then multiply and restoring divide (both skipped
// when clamped); the result is held until transferred, and the next item is taken the cycle
// after result transfer; a load gives no result and leaves the input ready
// reset sets entries_in_use to 53; table contents stay undefined until loaded
// depends on tli_pkg, tli_intf, tli_cell, tli_arith
`default_nettype none

module table_linear_interpolator_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tli_in_if.sink     in_i,
  tli_out_if.source  out_o,
  tli_cfg_if.sink    cfg_i
);

  logic [tli_pkg::COUNT_W-1:0] entries_in_use_q, count;
  logic                        busy_q, in_fire, out_fire;
  tli_pkg::load_t              load;
  tli_pkg::token_t             token [tli_pkg::TABLE_DEPTH+1];
  logic [tli_pkg::CODE_W-1:0]  cell_code [tli_pkg::TABLE_DEPTH];
  logic [tli_pkg::TEMP_W-1:0]  cell_temp [tli_pkg::TABLE_DEPTH];

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !busy_q;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= tli_pkg::ENTRIES_RESET;
      busy_q           <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        entries_in_use_q <= cfg_i.data;
      end
      if (in_fire && in_i.mode == tli_pkg::MODE_CONVERT) begin
        busy_q <= 1'b1;
      end else if (out_fire) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign count = (entries_in_use_q < tli_pkg::COUNT_MIN) ? tli_pkg::COUNT_MIN :
                 (entries_in_use_q > tli_pkg::COUNT_MAX) ? tli_pkg::COUNT_MAX :
                 entries_in_use_q;

  assign load.en    = in_fire && in_i.mode == tli_pkg::MODE_LOAD;
  assign load.index = in_i.entry_index;
  assign load.code  = in_i.entry_code;
  assign load.temp  = in_i.entry_temperature;

  always_comb begin
    token[0]        = '0;
    token[0].valid  = in_fire && in_i.mode == tli_pkg::MODE_CONVERT;
    token[0].status = tli_pkg::STATUS_INTERP;
    token[0].sample = in_i.sample;
  end

  for (genvar g = 0; g < tli_pkg::TABLE_DEPTH; g++) begin : g_cell
    logic [tli_pkg::CODE_W-1:0] prev_code;
    logic [tli_pkg::TEMP_W-1:0] prev_temp;

    if (g == 0) begin : g_first
      assign prev_code = '0;
      assign prev_temp = '0;
    end else begin : g_rest
      assign prev_code = cell_code[g-1];
      assign prev_temp = cell_temp[g-1];
    end

    tli_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (tli_pkg::INDEX_W'(g)),
      .count_i     (count),
      .load_i      (load),
      .prev_code_i (prev_code),
      .prev_temp_i (prev_temp),
      .code_o      (cell_code[g]),
      .temp_o      (cell_temp[g]),
      .token_i     (token[g]),
      .token_o     (token[g+1])
    );
  end

  tli_arith u_arith (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .token_i       (token[tli_pkg::TABLE_DEPTH]),
    .res_valid_o   (out_o.valid),
    .res_ready_i   (out_o.ready),
    .temperature_o (out_o.temperature),
    .status_o      (out_o.range_status)
  );

endmodule

`default_nettype wire

// File: dv/tb_table_linear_interpolator_unit.sv
`timescale 1ns / 100ps
// testbench of table_linear_interpolator_unit: calibration loads and sample conversions
// checked against an in-bench predictor, with random idling on both channels
// depends on tli_pkg, tli_intf and table_linear_interpolator_unit

module tb_table_linear_interpolator_unit;
  import tli_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 100;
  localparam int HOLD_CYCLES   = 500;
  localparam int IDLE_LIMIT    = 5000;

  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] index;
    logic [CODE_W-1:0]  code;
    logic [TEMP_W-1:0]  temp;
    logic [CODE_W-1:0]  sample;
    logic               drain_first;
  } sensor_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [1:0]        status;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tli_in_if  in_if ();
  tli_out_if out_if ();
  tli_cfg_if cfg_if ();

  table_linear_interpolator_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  sensor_item_t pending_items[$];
  reading_t     expected_readings[$];

  // predictor state, updated on each input and config transfer
  logic [CODE_W-1:0]  cal_code[TABLE_DEPTH];
  logic [TEMP_W-1:0]  cal_temp[TABLE_DEPTH];
  logic [COUNT_W-1:0] active_entries = ENTRIES_RESET;

  // what the stimulus generator knows of the tables
  bit                gen_written[TABLE_DEPTH];
  logic [CODE_W-1:0] gen_code[TABLE_DEPTH];
  int                gen_count;

  logic in_taken = 1'b0;
  logic result_taken = 1'b0;
  int   send_gap = 0, send_quiet = 0;
  int   stall_left = 0, stall_quiet = 0;
  int   hold_requests = 0, holds_served = 0;
  int   mismatch_count = 0;
  int   idle_cycles = 0;

  function automatic int clamp_count(input int value);
    if (value < COUNT_MIN) return COUNT_MIN;
    if (value > COUNT_MAX) return COUNT_MAX;
    return value;
  endfunction

  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      quiet_left = $urandom_range(5, 25);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  function automatic reading_t predict_reading(input logic [CODE_W-1:0] sample);
    int n, hit;
    logic [TEMP_W-1:0] adc_diff, temp_diff, data_diff, sub;
    logic [PROD_W-1:0] prod, quot;
    reading_t r;
    n = clamp_count(active_entries);
    hit = -1;
    for (int i = 0; i < n; i++)
      if (hit < 0 && cal_code[i] >= sample) hit = i;
    if (hit < 0) begin
      r.temperature = cal_temp[n-1];
      r.status = STATUS_ABOVE;
    end else if (hit == 0) begin
      r.temperature = cal_temp[0];
      r.status = STATUS_BELOW;
    end else begin
      // 16-bit wrapping differences, full-width product
      adc_diff  = TEMP_W'(cal_code[hit]) - TEMP_W'(cal_code[hit-1]);
      temp_diff = cal_temp[hit-1] - cal_temp[hit];
      data_diff = (TEMP_W'(sample) - TEMP_W'(cal_code[hit-1])) << FRACTION_BITS;
      prod = PROD_W'(temp_diff) * PROD_W'(data_diff);
      quot = (adc_diff != '0) ? prod / PROD_W'(adc_diff) : '0;
      sub  = TEMP_W'(quot >> FRACTION_BITS);
      r.temperature = cal_temp[hit-1] - sub;
      r.status = STATUS_INTERP;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_load(input int idx, input int code, input int temp);
    sensor_item_t it;
    it = '0;
    it.mode  = MODE_LOAD;
    it.index = INDEX_W'(idx);
    it.code  = CODE_W'(code);
    it.temp  = TEMP_W'(temp);
    pending_items.push_back(it);
    gen_written[idx] = 1'b1;
    gen_code[idx] = CODE_W'(code);
  endtask

  task automatic queue_convert(input int sample, input bit drain_first);
    sensor_item_t it;
    it = '0;
    it.mode = MODE_CONVERT;
    it.sample = CODE_W'(sample);
    it.drain_first = drain_first;
    // unwritten entries of the table are never read
    pending_items.push_back(it);
  endtask

  // ascending codes, non-increasing temperatures over entries 0 .. n-1
  task automatic queue_sorted_table(input int n);
    int code, temp;
    code = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
    temp = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(40000, 65535);
    for (int i = 0; i < n; i++) begin
      queue_load(i, code, temp);
      code += $urandom_range(1, 3800 / n);
      temp -= $urandom_range(0, 600);
    end
  endtask

  function automatic int pick_sample(input int n);
    int k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 7))
      0: return gen_code[k];
      1: return (int'(gen_code[k]) - 1) & 'hFFF;
      2: return (int'(gen_code[k]) + 1) & 'hFFF;
      3: return 0;
      4: return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic queue_mixed(input int items);
    for (int j = 0; j < items; j++) begin
      if ($urandom_range(0, 9) < 8)
        queue_convert(pick_sample(gen_count), $urandom_range(0, 29) == 0);
      else
        queue_load($urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 4095),
                   $urandom_range(0, 65535));
    end
  endtask

  task automatic wait_until_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || expected_readings.size() != 0 || in_if.valid);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entry_count(input int value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= COUNT_W'(value);
    do @(posedge clk_i);
    while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    gen_count = clamp_count(value & 'h7F);
  endtask

  // input transfers feed the predictor
  always @(posedge clk_i) begin
    in_taken <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      pending_items.delete(0);
      if (in_if.mode == MODE_LOAD) begin
        cal_code[in_if.entry_index] = in_if.entry_code;
        cal_temp[in_if.entry_index] = in_if.entry_temperature;
      end else begin
        expected_readings.push_back(predict_reading(in_if.sample));
      end
    end
    if (rst_ni && cfg_if.valid && cfg_if.ready) active_entries = cfg_if.data;
  end

  // driver
  always @(negedge clk_i) begin
    if (in_taken) send_gap = draw_wait(send_quiet);
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_taken) begin
      // offer stays until transfer
    end else if (send_gap > 0) begin
      in_if.valid <= 1'b0;
      send_gap--;
    end else if (pending_items.size() != 0 &&
                 !(pending_items[0].drain_first && expected_readings.size() != 0)) begin
      in_if.valid             <= 1'b1;
      in_if.mode              <= pending_items[0].mode;
      in_if.entry_index       <= pending_items[0].index;
      in_if.entry_code        <= pending_items[0].code;
      in_if.entry_temperature <= pending_items[0].temp;
      in_if.sample            <= pending_items[0].sample;
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // result ready, with random stalls and the requested long hold-off
  always @(negedge clk_i) begin
    if (result_taken) stall_left = draw_wait(stall_quiet);
    if (holds_served != hold_requests) begin
      holds_served++;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin : result_monitor
    reading_t want;
    result_taken <= out_if.valid && out_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_readings.size() == 0) begin
        note_mismatch($sformatf("unexpected result temperature %0d status %0d",
                                out_if.temperature, out_if.range_status));
      end else begin
        want = expected_readings.pop_front();
        if (out_if.temperature !== want.temperature)
          note_mismatch($sformatf("temperature expected %0d actual %0d",
                                  want.temperature, out_if.temperature));
        if (out_if.range_status !== want.status)
          note_mismatch($sformatf("range_status expected %0d actual %0d",
                                  want.status, out_if.range_status));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int entry_settings[8];
    bit complete;
    in_if.valid = 1'b0;
    in_if.mode = MODE_LOAD;
    in_if.entry_index = '0;
    in_if.entry_code = '0;
    in_if.entry_temperature = '0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part with two entries in use
    write_entry_count(2);
    queue_load(0, 100, 50000);
    queue_load(1, 4095, 0);
    queue_convert(0, 1'b0);
    queue_convert(100, 1'b0);
    queue_convert(101, 1'b0);
    queue_convert(4095, 1'b0);
    queue_load(1, 2000, 65535);
    queue_convert(4095, 1'b1);
    queue_convert(2000, 1'b0);
    queue_convert(1999, 1'b0);
    queue_load(0, 0, 0);
    queue_convert(0, 1'b0);
    queue_convert(1, 1'b0);
    queue_load(63, 4095, 65535);
    queue_load(0, 4095, 12345);
    queue_convert(3000, 1'b0);
    queue_convert(4095, 1'b0);
    wait_until_idle();

    entry_settings = '{64, 127, 0, 1, 100, 53, 9, 0};
    entry_settings[7] = $urandom_range(2, 64);
    foreach (entry_settings[p]) begin
      write_entry_count(entry_settings[p]);
      complete = 1'b1;
      for (int i = 0; i < gen_count; i++)
        if (!gen_written[i]) complete = 1'b0;
      if (!complete || $urandom_range(0, 1) == 0) queue_sorted_table(gen_count);
      if (p == 2 || p == 6) hold_requests++;
      queue_mixed(35);
      wait_until_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: table_linear_interpolator_unit.f
sv/tli_pkg.sv
sv/tli_intf.sv
sv/tli_cell.sv
sv/tli_arith.sv
sv/table_linear_interpolator_unit.sv
dv/tb_table_linear_interpolator_unit.sv
